// File: rtl/core/prr_pkg.sv
package prr_pkg;

   // Defaults for the top level parameters.
   localparam int MAX_PHASES_DEF     = 64;
   localparam int TAPS_PER_PHASE_DEF = 32;
   localparam int HISTORY_DEPTH_DEF  = 64;
   localparam int SAMPLE_WIDTH_DEF   = 16;
   localparam int COEF_WIDTH_DEF     = 18;

   // Fixed field and register widths.
   localparam int UP_WIDTH         = 7;
   localparam int DOWN_WIDTH       = 10;
   localparam int PHASE_WIDTH      = 11;
   localparam int CSR_DATA_WIDTH   = 10;
   localparam int CSR_INDEX_WIDTH  = 1;
   localparam int COEF_PHASE_WIDTH = 6;
   localparam int COEF_TAP_WIDTH   = 5;

   // Register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UP_FACTOR   = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DOWN_FACTOR = 1'b1;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_LOAD = 1'b1
   } prr_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_ROUND,
      ST_OUT
   } prr_state_type;

endpackage

// File: rtl/core/polyphase_rational_resampler_top.sv
// Polyphase rational resampler, complex I/Q, ratio up_factor / down_factor.
//
// req channel: one beat is either a sample push (req_op = push) or one
// coefficient load (req_op = load, address req_coef_phase / req_coef_tap).
// rsp channel: zero or more filtered I/Q beats per push; rsp_run_end marks
// the last beat caused by that push. A load makes no rsp beat.
// csr port: csr_write with csr_index 0 sets up_factor, 1 sets down_factor.
// Write only while idle.
//
// Timing: a load leaves req_stall low. A push holds req_stall high until all
// of its outputs are delivered. Each output is made by one shared complex MAC
// (two real multipliers on one coefficient) that walks the taps one per
// cycle, fed by the history and coefficient memory read ports, then a 3-stage
// drain and a round/saturate state; the receiver can hold the result beat
// with rsp_stall. A push that makes no output leaves req_stall low.
//
// Reset (synchronous, active high) clears the sample history (per-entry
// valid bits), write pointer and phase, and sets both factors to 1. The
// coefficient memory is not cleared. While rsp_stall is high during a
// result beat, the beat holds and the block accepts nothing.
module polyphase_rational_resampler_top #(
   parameter int MAX_PHASES     = prr_pkg::MAX_PHASES_DEF,
   parameter int TAPS_PER_PHASE = prr_pkg::TAPS_PER_PHASE_DEF,
   parameter int HISTORY_DEPTH  = prr_pkg::HISTORY_DEPTH_DEF,
   parameter int SAMPLE_WIDTH   = prr_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_WIDTH     = prr_pkg::COEF_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration
   input  logic                                   csr_write,
   input  logic [prr_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [prr_pkg::CSR_DATA_WIDTH-1:0]     csr_data,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_op,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_sample_i,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_sample_q,
   input  logic [prr_pkg::COEF_PHASE_WIDTH-1:0]   req_coef_phase,
   input  logic [prr_pkg::COEF_TAP_WIDTH-1:0]     req_coef_tap,
   input  logic signed [COEF_WIDTH-1:0]           req_coef_value,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]         rsp_out_i,
   output logic signed [SAMPLE_WIDTH-1:0]         rsp_out_q,
   output logic                                   rsp_run_end
);

   localparam int PHW   = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
   localparam int TCW   = $clog2(TAPS_PER_PHASE);
   localparam int HPW   = $clog2(HISTORY_DEPTH);
   localparam int CDEP  = MAX_PHASES * TAPS_PER_PHASE;
   localparam int CAW   = (CDEP > 1) ? $clog2(CDEP) : 1;
   localparam int PW    = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int ACCW  = PW + TCW;
   localparam int RW    = ACCW - COEF_WIDTH + 1;
   localparam int UPW   = prr_pkg::UP_WIDTH;
   localparam int DNW   = prr_pkg::DOWN_WIDTH;
   localparam int PHSW  = prr_pkg::PHASE_WIDTH;

   localparam logic [ACCW-1:0] RND_BIAS = ACCW'(1) << (COEF_WIDTH - 2);
   localparam logic [SAMPLE_WIDTH-1:0] SAT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic [SAMPLE_WIDTH-1:0] SAT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam logic [TCW-1:0] TAP_LAST = TCW'(TAPS_PER_PHASE - 1);
   localparam logic [HPW-1:0] HIST_LAST = HPW'(HISTORY_DEPTH - 1);

   prr_pkg::prr_state_type state_ff, state_in;

   // config registers
   logic [UPW-1:0]  up_ff, up_in;
   logic [DNW-1:0]  down_ff, down_in;

   // control
   logic [HPW-1:0]  wp_ff, wp_in;
   logic [HPW-1:0]  base_ff, base_in;
   logic [HPW-1:0]  rp_ff, rp_in;
   logic [TCW-1:0]  tap_ff, tap_in;
   logic [PHSW-1:0] phase_ff, phase_in;
   logic [HISTORY_DEPTH-1:0] hvld_ff, hvld_in;
   logic            s1_vld_ff, s1_last_ff, s2_vld_ff, s2_last_ff, s3_last_ff;

   // datapath
   logic [2*SAMPLE_WIDTH-1:0] hist_mem [HISTORY_DEPTH];
   logic [COEF_WIDTH-1:0]     coef_mem [CDEP];
   logic [2*SAMPLE_WIDTH-1:0] hist_rd_ff;
   logic                      hist_rd_vld_ff;
   logic signed [COEF_WIDTH-1:0] coef_rd_ff;
   logic signed [PW-1:0]      prod_i_ff, prod_q_ff, prod_i_in, prod_q_in;
   logic signed [ACCW-1:0]    acc_i_ff, acc_q_ff, acc_i_in, acc_q_in;
   logic [SAMPLE_WIDTH-1:0]   out_i_ff, out_q_ff, out_i_in, out_q_in;
   logic                      run_end_ff, run_end_in;

   // handshakes and decode
   logic                      req_fire, rsp_fire, push, load, coef_in_range;
   logic [CAW-1:0]            coef_wr_addr, coef_rd_addr;
   logic [UPW-1:0]            l_eff;
   logic [DNW-1:0]            m_eff;
   logic [PHSW-1:0]           l_ext, phase_nxt;
   logic                      phase_below;
   logic                      issue;
   logic signed [SAMPLE_WIDTH-1:0] smp_i, smp_q;

   assign req_fire = req_valid && !req_stall;
   assign rsp_fire = rsp_valid && !rsp_stall;
   assign push     = req_fire && (req_op == prr_pkg::OP_PUSH);
   assign load     = req_fire && (req_op == prr_pkg::OP_LOAD);

   assign coef_in_range = ({1'b0, req_coef_phase} < (prr_pkg::COEF_PHASE_WIDTH+1)'(MAX_PHASES))
                       && ({1'b0, req_coef_tap} < (prr_pkg::COEF_TAP_WIDTH+1)'(TAPS_PER_PHASE));
   assign coef_wr_addr  = CAW'(req_coef_phase) * CAW'(TAPS_PER_PHASE) + CAW'(req_coef_tap);
   assign coef_rd_addr  = CAW'(phase_ff[PHW-1:0]) * CAW'(TAPS_PER_PHASE) + CAW'(tap_ff);

   // effective factors: L clamped into [1, MAX_PHASES], M zero means 1
   always_comb begin
      if (up_ff == '0) begin
         l_eff = UPW'(1);
      end else if (up_ff > UPW'(MAX_PHASES)) begin
         l_eff = UPW'(MAX_PHASES);
      end else begin
         l_eff = up_ff;
      end
      m_eff = (down_ff == '0) ? DNW'(1) : down_ff;
   end

   assign l_ext       = PHSW'(l_eff);
   assign phase_below = phase_ff < l_ext;
   assign phase_nxt   = phase_ff + PHSW'(m_eff);

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         prr_pkg::ST_IDLE: begin
            if (push && phase_below) begin
               state_in = prr_pkg::ST_MAC;
            end
         end
         prr_pkg::ST_MAC: begin
            if (tap_ff == TAP_LAST) begin
               state_in = prr_pkg::ST_DRAIN;
            end
         end
         prr_pkg::ST_DRAIN: begin
            if (s3_last_ff) begin
               state_in = prr_pkg::ST_ROUND;
            end
         end
         prr_pkg::ST_ROUND: begin
            state_in = prr_pkg::ST_OUT;
         end
         prr_pkg::ST_OUT: begin
            if (rsp_fire) begin
               state_in = run_end_ff ? prr_pkg::ST_IDLE : prr_pkg::ST_MAC;
            end
         end
         default: begin
            state_in = prr_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      issue     = 1'b0;
      case (state_ff)
         prr_pkg::ST_IDLE:  req_stall = 1'b0;
         prr_pkg::ST_MAC:   issue     = 1'b1;
         prr_pkg::ST_DRAIN: ;
         prr_pkg::ST_ROUND: ;
         prr_pkg::ST_OUT:   rsp_valid = 1'b1;
         default:           ;
      endcase
   end

   // ---------------- control next values ----------------
   always_comb begin
      up_in    = up_ff;
      down_in  = down_ff;
      wp_in    = wp_ff;
      base_in  = base_ff;
      rp_in    = rp_ff;
      tap_in   = tap_ff;
      phase_in = phase_ff;
      hvld_in  = hvld_ff;
      run_end_in = run_end_ff;

      if (csr_write) begin
         case (csr_index)
            prr_pkg::CSR_UP_FACTOR:   up_in   = csr_data[UPW-1:0];
            prr_pkg::CSR_DOWN_FACTOR: down_in = csr_data[DNW-1:0];
            default: ;
         endcase
      end

      if (push) begin
         hvld_in[wp_ff] = 1'b1;
         base_in = wp_ff;
         rp_in   = wp_ff;
         tap_in  = '0;
         wp_in   = (wp_ff == HIST_LAST) ? '0 : wp_ff + HPW'(1);
         if (!phase_below) begin
            phase_in = phase_ff - l_ext;
         end
      end

      if (issue) begin
         tap_in = tap_ff + TCW'(1);
         rp_in  = (rp_ff == '0) ? HIST_LAST : rp_ff - HPW'(1);
      end

      // one output done: advance phase, rewind the walk for the next branch
      if (state_ff == prr_pkg::ST_ROUND) begin
         run_end_in = phase_nxt >= l_ext;
         phase_in   = (phase_nxt >= l_ext) ? phase_nxt - l_ext : phase_nxt;
         rp_in      = base_ff;
         tap_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= prr_pkg::ST_IDLE;
         up_ff      <= UPW'(1);
         down_ff    <= DNW'(1);
         wp_ff      <= '0;
         base_ff    <= '0;
         rp_ff      <= '0;
         tap_ff     <= '0;
         phase_ff   <= '0;
         hvld_ff    <= '0;
         run_end_ff <= 1'b0;
         s1_vld_ff  <= 1'b0;
         s1_last_ff <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s2_last_ff <= 1'b0;
         s3_last_ff <= 1'b0;
         acc_i_ff   <= '0;
         acc_q_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         up_ff      <= up_in;
         down_ff    <= down_in;
         wp_ff      <= wp_in;
         base_ff    <= base_in;
         rp_ff      <= rp_in;
         tap_ff     <= tap_in;
         phase_ff   <= phase_in;
         hvld_ff    <= hvld_in;
         run_end_ff <= run_end_in;
         s1_vld_ff  <= issue;
         s1_last_ff <= issue && (tap_ff == TAP_LAST);
         s2_vld_ff  <= s1_vld_ff;
         s2_last_ff <= s1_last_ff;
         s3_last_ff <= s2_vld_ff && s2_last_ff;
         acc_i_ff   <= acc_i_in;
         acc_q_ff   <= acc_q_in;
      end
   end

   // ---------------- memories ----------------
   always_ff @(posedge clock) begin
      if (push) begin
         hist_mem[wp_ff] <= {req_sample_i, req_sample_q};
      end
      hist_rd_ff     <= hist_mem[rp_ff];
      hist_rd_vld_ff <= hvld_ff[rp_ff];
   end

   always_ff @(posedge clock) begin
      if (load && coef_in_range) begin
         coef_mem[coef_wr_addr] <= req_coef_value;
      end
      coef_rd_ff <= coef_mem[coef_rd_addr];
   end

   // ---------------- shared complex MAC ----------------
   // history entries never written since reset read as zero
   assign smp_i = hist_rd_vld_ff ? hist_rd_ff[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH] : '0;
   assign smp_q = hist_rd_vld_ff ? hist_rd_ff[SAMPLE_WIDTH-1:0] : '0;

   assign prod_i_in = PW'(smp_i) * PW'(coef_rd_ff);
   assign prod_q_in = PW'(smp_q) * PW'(coef_rd_ff);

   always_ff @(posedge clock) begin
      prod_i_ff <= prod_i_in;
      prod_q_ff <= prod_q_in;
   end

   always_comb begin
      acc_i_in = acc_i_ff;
      acc_q_in = acc_q_ff;
      if ((state_ff == prr_pkg::ST_IDLE) || (state_ff == prr_pkg::ST_ROUND)) begin
         acc_i_in = '0;
         acc_q_in = '0;
      end else if (s2_vld_ff) begin
         acc_i_in = acc_i_ff + {{(ACCW-PW){prod_i_ff[PW-1]}}, prod_i_ff};
         acc_q_in = acc_q_ff + {{(ACCW-PW){prod_q_ff[PW-1]}}, prod_q_ff};
      end
   end

   // ---------------- round half up, saturate ----------------
   function automatic logic [SAMPLE_WIDTH-1:0] rnd_sat(input logic [ACCW-1:0] acc);
      logic [ACCW-1:0] biased;
      logic [RW-1:0]   shifted;
      logic [RW-SAMPLE_WIDTH:0] upper;
      biased  = acc + RND_BIAS;
      shifted = biased[ACCW-1:COEF_WIDTH-1];
      upper   = shifted[RW-1:SAMPLE_WIDTH-1];
      if ((&upper) || !(|upper)) begin
         return shifted[SAMPLE_WIDTH-1:0];
      end
      return shifted[RW-1] ? SAT_MIN : SAT_MAX;
   endfunction

   assign out_i_in = rnd_sat(acc_i_ff);
   assign out_q_in = rnd_sat(acc_q_ff);

   always_ff @(posedge clock) begin
      if (state_ff == prr_pkg::ST_ROUND) begin
         out_i_ff <= out_i_in;
         out_q_ff <= out_q_in;
      end
   end

   assign rsp_out_i   = out_i_ff;
   assign rsp_out_q   = out_q_ff;
   assign rsp_run_end = run_end_ff;

endmodule

// File: rtl/core/prr_checker.sv
module prr_checker #(
   parameter int SAMPLE_WIDTH = prr_pkg::SAMPLE_WIDTH_DEF
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    req_op,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [SAMPLE_WIDTH-1:0] rsp_out_i,
   input logic [SAMPLE_WIDTH-1:0] rsp_out_q,
   input logic                    rsp_run_end
);

   // after reset: idle, nothing pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

   // a pending result keeps the request side closed
   a_busy_on_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while a result is pending");

   // coefficient load makes no result and leaves the block open
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_op == prr_pkg::OP_LOAD) |=> !rsp_valid && !req_stall)
      else $error("coefficient load produced a result or stalled");

   // more outputs of the same push follow a beat without run_end
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_run_end |=> req_stall && !rsp_valid)
      else $error("run ended without run_end");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_i) && $stable(rsp_out_q)
                                 && $stable(rsp_run_end))
      else $error("stalled result beat changed");

endmodule

bind polyphase_rational_resampler_top prr_checker #(
   .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_prr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_op      (req_op),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_out_i   (rsp_out_i),
   .rsp_out_q   (rsp_out_q),
   .rsp_run_end (rsp_run_end)
);
